### design/lge_pkg.sv
// Shared types and command codes for the life grid engine.
`default_nettype none
package lge_pkg;

    localparam int CMD_W   = 2;
    localparam int COORD_W = 6;
    localparam int ROW_W   = 64;

    // Command codes carried in the input transfer
    localparam logic [CMD_W-1:0] CMD_TOGGLE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RUN    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FRAME  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
    } t_in;

    typedef struct packed {
        logic [COORD_W-1:0] row_index;
        logic [ROW_W-1:0]   row_bits;
        logic               last_row;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TG_RD,
        ST_TG_WR,
        ST_FR_START,
        ST_FR_LOAD,
        ST_FR_ROW
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic run_tog;
        logic tog_rd;
        logic tog_wr;
        logic fr_start;
        logic fr_load;
        logic fr_row;
        logic fr_step;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
        logic last_row;
    } t_dp_sts;

endpackage
`default_nettype wire

### design/lge_ctrl.sv
// Command sequencer for the life grid engine.
`default_nettype none
module lge_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [1:0]       i_cmd,
    output logic                  o_ready,
    input  wire lge_pkg::t_dp_sts i_sts,
    output lge_pkg::t_dp_cmd      o_cmd
);
    import lge_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    unique case (i_cmd)
                        CMD_TOGGLE: n_state = ST_TG_RD;
                        CMD_RUN:    o_cmd.run_tog = 1'b1;
                        CMD_FRAME:  n_state = ST_FR_START;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_TG_RD: begin
                o_cmd.tog_rd = 1'b1;
                n_state      = ST_TG_WR;
            end
            ST_TG_WR: begin
                o_cmd.tog_wr = 1'b1;
                n_state      = ST_IDLE;
            end
            ST_FR_START: begin
                o_cmd.fr_start = 1'b1;
                n_state        = ST_FR_LOAD;
            end
            ST_FR_LOAD: begin
                o_cmd.fr_load = 1'b1;
                n_state       = ST_FR_ROW;
            end
            ST_FR_ROW: begin
                o_cmd.fr_row  = 1'b1;
                o_cmd.fr_step = i_sts.out_free;
                if (i_sts.out_free && i_sts.last_row) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

### design/lge_datapath.sv
// Grid memory, row window, cell update logic and output register.
`default_nettype none
module lge_datapath #(
    parameter int GRID_SIDE = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire lge_pkg::t_in     i_data,
    input  wire lge_pkg::t_dp_cmd i_cmd,
    output lge_pkg::t_dp_sts      o_sts,
    input  wire logic             i_ready,
    output logic                  o_valid,
    output lge_pkg::t_out         o_data
);
    import lge_pkg::*;

    localparam int AW = $clog2(GRID_SIDE);
    localparam int YW = AW + 1;

    // One generation for one row, outside cells dead
    function automatic logic [GRID_SIDE-1:0] life_row(
        input logic [GRID_SIDE-1:0] above,
        input logic [GRID_SIDE-1:0] here,
        input logic [GRID_SIDE-1:0] below
    );
        logic [GRID_SIDE+1:0] pa;
        logic [GRID_SIDE+1:0] ph;
        logic [GRID_SIDE+1:0] pb;
        logic [3:0]           n;
        logic [GRID_SIDE-1:0] res;
        pa  = {1'b0, above, 1'b0};
        ph  = {1'b0, here, 1'b0};
        pb  = {1'b0, below, 1'b0};
        res = '0;
        for (int x = 0; x < GRID_SIDE; x++) begin
            n = 4'(pa[x]) + 4'(pa[x+1]) + 4'(pa[x+2])
              + 4'(ph[x]) + 4'(ph[x+2])
              + 4'(pb[x]) + 4'(pb[x+1]) + 4'(pb[x+2]);
            res[x] = (n == 4'd3) || (here[x] && (n == 4'd2));
        end
        return res;
    endfunction

    logic [GRID_SIDE-1:0] r_mem [GRID_SIDE];
    logic [GRID_SIDE-1:0] r_vld;
    logic [GRID_SIDE-1:0] r_rdata;
    logic                 r_rd_live;
    logic [COORD_W-1:0]   r_cx;
    logic [COORD_W-1:0]   r_cy;
    logic                 r_run;
    logic [YW-1:0]        r_y;
    logic [GRID_SIDE-1:0] r_above;
    logic [GRID_SIDE-1:0] r_here;
    logic                 r_ovld;
    t_out                 r_out;

    logic                 tog_ok;
    logic [GRID_SIDE-1:0] below;
    logic [GRID_SIDE-1:0] new_row;
    logic                 out_free;
    logic                 rd_en;
    logic                 rd_in;
    logic [AW-1:0]        rd_idx;
    logic [YW-1:0]        rd_full;
    logic                 wr_en;
    logic [AW-1:0]        wr_idx;
    logic [GRID_SIDE-1:0] wr_data;

    assign tog_ok   = ({1'b0, r_cx} < 7'(GRID_SIDE)) && ({1'b0, r_cy} < 7'(GRID_SIDE));
    assign below    = r_rd_live ? r_rdata : '0;
    assign new_row  = r_run ? life_row(r_above, r_here, below) : r_here;
    assign out_free = !r_ovld || i_ready;

    assign o_sts.out_free = out_free;
    assign o_sts.last_row = (r_y == YW'(GRID_SIDE - 1));

    // Read address: toggle row, first row of a frame, or the row below the window
    always_comb begin
        rd_full = '0;
        if (i_cmd.fr_load) begin
            rd_full = r_y + YW'(1);
        end else if (i_cmd.fr_row) begin
            rd_full = i_cmd.fr_step ? r_y + YW'(2) : r_y + YW'(1);
        end
        rd_en  = 1'b1;
        rd_in  = rd_full < YW'(GRID_SIDE);
        rd_idx = rd_full[AW-1:0];
        if (i_cmd.tog_rd) begin
            rd_in  = tog_ok;
            rd_idx = r_cy[AW-1:0];
        end else if (!(i_cmd.fr_start || i_cmd.fr_load || i_cmd.fr_row)) begin
            rd_en = 1'b0;
        end
    end

    // Write port: toggled row or updated row
    always_comb begin
        wr_en   = 1'b0;
        wr_idx  = r_y[AW-1:0];
        wr_data = new_row;
        if (i_cmd.tog_wr) begin
            wr_en   = tog_ok;
            wr_idx  = r_cy[AW-1:0];
            wr_data = below ^ (GRID_SIDE'(1) << r_cx[AW-1:0]);
        end else if (i_cmd.fr_step) begin
            wr_en = r_run;
        end
    end

    // Grid memory, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_idx] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_idx];
        end
    end

    // Row valid bits stand in for clearing the grid at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_rd_live <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vld[wr_idx] <= 1'b1;
            end
            if (rd_en) begin
                r_rd_live <= rd_in && r_vld[rd_idx];
            end
        end
    end

    // Run flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else if (i_cmd.run_tog) begin
            r_run <= !r_run;
        end
    end

    // Command capture and row window
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cx <= i_data.cell_x;
            r_cy <= i_data.cell_y;
        end
        if (i_cmd.fr_start) begin
            r_y     <= '0;
            r_above <= '0;
        end
        if (i_cmd.fr_load) begin
            r_here <= below;
        end
        if (i_cmd.fr_step) begin
            r_above <= r_here;
            r_here  <= below;
            r_y     <= r_y + YW'(1);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (i_cmd.fr_step) begin
            r_ovld <= 1'b1;
        end else if (i_ready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fr_step) begin
            r_out.row_index <= COORD_W'(r_y);
            r_out.row_bits  <= ROW_W'(new_row);
            r_out.last_row  <= (r_y == YW'(GRID_SIDE - 1));
        end
    end

    assign o_valid = r_ovld;
    assign o_data  = r_out;

endmodule
`default_nettype wire

### design/life_grid_engine.sv
// Top level of the life grid engine: controller plus datapath.
//
// Conway life on a GRID_SIDE x GRID_SIDE grid (4..64), dead cells past the edges.
// A run-flag command is handled in the idle state; a cell toggle is a read, modify, write of
// one grid row. For a frame command the grid memory gives one row per cycle, while the output
// side does not stall, through its single read port, and each row is updated in the same
// cycle it is presented. The last row sits in the output register while the next command
// is taken. Reset clears the grid at once through per-row valid bits; no clearing sweep
// is needed.
`default_nettype none
module life_grid_engine #(
    parameter int GRID_SIDE = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire lge_pkg::t_in  i_data,
    output logic               o_valid,
    input  wire logic          i_ready,
    output lge_pkg::t_out      o_data
);
    import lge_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    lge_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_cmd   (i_data.cmd),
        .o_ready (o_ready),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd)
    );

    lge_datapath #(
        .GRID_SIDE (GRID_SIDE)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (i_data),
        .i_cmd   (dp_cmd),
        .o_sts   (dp_sts),
        .i_ready (i_ready),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

endmodule
`default_nettype wire

### tb/sv/tb.sv
// Testbench for life_grid_engine: directed and random commands checked against a cell-grid model.
`default_nettype none
module tb;
    import lge_pkg::*;

    localparam int SIDE = 64;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int RAND_PER_PHASE = 144;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_valid;
    logic  o_ready;
    t_in   i_data;
    logic  o_valid;
    logic  i_ready;
    t_out  o_data;

    // Idle percentages for the sender and the receiver
    int snd_idle;
    int rcv_idle;

    // Hot spot for clustered toggles, so that patterns actually evolve
    int hot_x;
    int hot_y;

    life_grid_engine #(.GRID_SIDE(SIDE)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    // Grid model: keeps its own cells and run flag, queues the rows each frame must emit
    class life_grid_model;
        logic [ROW_W-1:0] cells [SIDE];
        bit               running;
        t_out             rows_due [$];
        int               errors;

        function new();
            for (int y = 0; y < SIDE; y++) cells[y] = '0;
            running = 1'b0;
            errors  = 0;
        endfunction

        // One Conway generation, dead cells outside the grid
        function void advance_generation();
            logic [ROW_W-1:0] prev [SIDE];
            int n;
            int yy;
            int xx;
            prev = cells;
            for (int y = 0; y < SIDE; y++) begin
                for (int x = 0; x < SIDE; x++) begin
                    n = 0;
                    for (int dy = -1; dy <= 1; dy++) begin
                        for (int dx = -1; dx <= 1; dx++) begin
                            yy = y + dy;
                            xx = x + dx;
                            if ((dy != 0 || dx != 0) && yy >= 0 && yy < SIDE &&
                                xx >= 0 && xx < SIDE)
                                n += prev[yy][xx];
                        end
                    end
                    cells[y][x] = prev[y][x] ? (n == 2 || n == 3) : (n == 3);
                end
            end
        endfunction

        // Apply one accepted command and queue the rows it produces
        function void apply_command(t_in cmd_in);
            t_out row;
            case (cmd_in.cmd)
                CMD_TOGGLE: begin
                    if (cmd_in.cell_x < SIDE && cmd_in.cell_y < SIDE)
                        cells[cmd_in.cell_y][cmd_in.cell_x] = ~cells[cmd_in.cell_y][cmd_in.cell_x];
                end
                CMD_RUN: running = ~running;
                CMD_FRAME: begin
                    if (running) advance_generation();
                    for (int y = 0; y < SIDE; y++) begin
                        row.row_index = COORD_W'(y);
                        row.row_bits  = cells[y];
                        row.last_row  = (y == SIDE - 1);
                        rows_due.push_back(row);
                    end
                end
                default: ;
            endcase
        endfunction

        // Compare one emitted row with the oldest one due
        function void check_row(t_out got);
            t_out want;
            if (rows_due.size() == 0) begin
                $display("%0t: unexpected row transfer: index %0d bits %h last %b",
                         $time, got.row_index, got.row_bits, got.last_row);
                errors++;
                return;
            end
            want = rows_due.pop_front();
            if (got.row_index !== want.row_index) begin
                $display("%0t: row_index expected %0d actual %0d",
                         $time, want.row_index, got.row_index);
                errors++;
            end
            if (got.row_bits !== want.row_bits) begin
                $display("%0t: row_bits (row %0d) expected %h actual %h",
                         $time, want.row_index, want.row_bits, got.row_bits);
                errors++;
            end
            if (got.last_row !== want.last_row) begin
                $display("%0t: last_row (row %0d) expected %b actual %b",
                         $time, want.row_index, want.last_row, got.last_row);
                errors++;
            end
        endfunction

        function int rows_pending();
            return rows_due.size();
        endfunction
    endclass

    life_grid_model model;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Receiver back-pressure
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= rcv_idle);
    end

    // Row monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) model.check_row(o_data);
    end

    // Watchdog
    initial begin
        #(20 * 500000);
        $display("tb: done, errors");
        $finish;
    end

    function automatic t_in make_cmd(logic [CMD_W-1:0] c, int x, int y);
        t_in it;
        it.cmd    = c;
        it.cell_x = COORD_W'(x);
        it.cell_y = COORD_W'(y);
        return it;
    endfunction

    // Random command: mostly toggles, most clustered around a hot spot, with frames, run commands and noise
    function automatic t_in random_cmd();
        int r;
        r = $urandom_range(99);
        if (r < 4)
            return make_cmd(CMD_UNUSED, $urandom_range(63), $urandom_range(63));
        if (r < 8)
            return make_cmd(CMD_RUN, $urandom_range(63), $urandom_range(63));
        if (r < 22)
            return make_cmd(CMD_FRAME, $urandom_range(63), $urandom_range(63));
        if ($urandom_range(99) < 65)
            return make_cmd(CMD_TOGGLE, hot_x + $urandom_range(7), hot_y + $urandom_range(7));
        return make_cmd(CMD_TOGGLE, $urandom_range(63), $urandom_range(63));
    endfunction

    function automatic int pick_hot();
        case ($urandom_range(2))
            0:       return 0;
            1:       return SIDE - 8;
            default: return $urandom_range(SIDE - 8);
        endcase
    endfunction

    // One input transfer; entered and left at a falling edge
    task automatic send_cmd(t_in it);
        int gap;
        gap = 0;
        while ($urandom_range(99) < snd_idle) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        model.apply_command(it);
        @(negedge i_clk);
    endtask

    // Hold the sender off until every queued row has been seen
    task automatic drain_rows();
        i_valid <= 1'b0;
        while (model.rows_pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++) begin
            if (i % 30 == 0) begin
                hot_x = pick_hot();
                hot_y = pick_hot();
            end
            send_cmd(random_cmd());
        end
    endtask

    // Main sequence
    initial begin
        model    = new();
        i_rst_n  = 1'b0;
        i_valid  = 1'b0;
        i_data   = '0;
        i_ready  = 1'b0;
        snd_idle = 13;
        rcv_idle = 58;
        hot_x    = 0;
        hot_y    = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty grid, corners, unused command, edge blinker and a four-cell corner block
        send_cmd(make_cmd(CMD_FRAME, 0, 0));
        send_cmd(make_cmd(CMD_TOGGLE, 0, 0));
        send_cmd(make_cmd(CMD_TOGGLE, 63, 0));
        send_cmd(make_cmd(CMD_TOGGLE, 0, 63));
        send_cmd(make_cmd(CMD_TOGGLE, 63, 63));
        send_cmd(make_cmd(CMD_TOGGLE, 0, 0));
        send_cmd(make_cmd(CMD_UNUSED, 63, 63));
        send_cmd(make_cmd(CMD_FRAME, 63, 63));
        send_cmd(make_cmd(CMD_RUN, 0, 0));
        send_cmd(make_cmd(CMD_FRAME, 0, 0));
        send_cmd(make_cmd(CMD_TOGGLE, 0, 20));
        send_cmd(make_cmd(CMD_TOGGLE, 0, 21));
        send_cmd(make_cmd(CMD_TOGGLE, 0, 22));
        send_cmd(make_cmd(CMD_TOGGLE, 62, 62));
        send_cmd(make_cmd(CMD_TOGGLE, 63, 62));
        send_cmd(make_cmd(CMD_TOGGLE, 62, 63));
        send_cmd(make_cmd(CMD_TOGGLE, 63, 63));
        send_cmd(make_cmd(CMD_FRAME, 0, 0));
        send_cmd(make_cmd(CMD_FRAME, 0, 0));
        send_cmd(make_cmd(CMD_RUN, 63, 63));
        send_cmd(make_cmd(CMD_FRAME, 0, 0));

        random_phase(RAND_PER_PHASE);
        drain_rows();

        snd_idle = 58;
        rcv_idle = 13;
        random_phase(RAND_PER_PHASE);
        drain_rows();

        snd_idle = 0;
        rcv_idle = 0;
        random_phase(RAND_PER_PHASE);

        // Wind down: every row in, then a further wait for strays
        drain_rows();
        repeat (SIDE + 8) @(posedge i_clk);
        if (model.errors == 0 && model.rows_pending() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
`default_nettype wire
